[hdl/ground_roll_phase_counter_unit_defines.svh]
// ----------------------------------------------------------------------------
// Ground roll phase counter assertion macros
// Shared property forms for the concurrent checks of the unit.
// ----------------------------------------------------------------------------
`ifndef GROUND_ROLL_PHASE_COUNTER_UNIT_DEFINES_SVH
`define GROUND_ROLL_PHASE_COUNTER_UNIT_DEFINES_SVH

// Check cons in the same cycle as ante.
`define GRPC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define GRPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/grpc_pkg.sv]
// ----------------------------------------------------------------------------
// Ground roll phase counter package
// Phase and request codes, register indexes and the beat structures.
// ----------------------------------------------------------------------------
package grpc_pkg;

   localparam int LOAD_W  = 10;
   localparam int CNT_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CNT_W-1:0] HOLD_TICKS_RESET = 16'd500;

   typedef enum logic [2:0] {
      PH_GROUND     = 3'd0,
      PH_ROLL       = 3'd1,
      PH_LIFT_PEND  = 3'd2,
      PH_AIRBORNE   = 3'd3,
      PH_TOUCH_PEND = 3'd4,
      PH_LANDED     = 3'd5,
      PH_DONE       = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      REQ_SAMPLE      = 2'd0,
      REQ_TICK        = 2'd1,
      REQ_PULSE_LEFT  = 2'd2,
      REQ_PULSE_RIGHT = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIMIT_LEFT  = 2'd0,
      CSR_LIMIT_RIGHT = 2'd1,
      CSR_HOLD_TICKS  = 2'd2
   } csr_index_type;

   typedef struct packed {
      req_kind_type      kind;
      logic [LOAD_W-1:0] left_load;
      logic [LOAD_W-1:0] right_load;
   } step_item_type;

   typedef struct packed {
      logic [LOAD_W-1:0] limit_left;
      logic [LOAD_W-1:0] limit_right;
      logic [CNT_W-1:0]  hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0] landing_pulses;
      logic [CNT_W-1:0] takeoff_pulses;
      logic [2:0]       phase;
   } result_type;

endpackage

[hdl/grpc_cfg.sv]
// ----------------------------------------------------------------------------
// Ground roll phase counter configuration registers
// Holds the two load limits and the confirmation hold count.
// ----------------------------------------------------------------------------
module grpc_cfg
   import grpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LIMIT_LEFT:  cfg_in.limit_left  = csr_wdata[LOAD_W-1:0];
            CSR_LIMIT_RIGHT: cfg_in.limit_right = csr_wdata[LOAD_W-1:0];
            CSR_HOLD_TICKS:  cfg_in.hold_ticks  = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit_left  <= '0;
         cfg_ff.limit_right <= '0;
         cfg_ff.hold_ticks  <= HOLD_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/grpc_engine.sv]
// ----------------------------------------------------------------------------
// Ground roll phase counter engine
// Phase state, hold timer and pulse counters, updated once per beat.
// ----------------------------------------------------------------------------
`include "ground_roll_phase_counter_unit_defines.svh"

module grpc_engine
   import grpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step_en,
   input  step_item_type item,
   input  cfg_type       cfg,
   output result_type    result
);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] hold_timer_ff, hold_timer_in;
   logic             timer_running_ff, timer_running_in;
   logic [CNT_W-1:0] takeoff_left_ff, takeoff_left_in;
   logic [CNT_W-1:0] takeoff_right_ff, takeoff_right_in;
   logic [CNT_W-1:0] pending_left_ff, pending_left_in;
   logic [CNT_W-1:0] pending_right_ff, pending_right_in;
   logic [CNT_W-1:0] landing_left_ff, landing_left_in;
   logic [CNT_W-1:0] landing_right_ff, landing_right_in;

   logic lifted;
   logic touching;
   logic any_high;
   logic left_high;
   logic right_high;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] larger(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   assign left_high  = item.left_load > cfg.limit_left;
   assign right_high = item.right_load > cfg.limit_right;
   assign lifted     = left_high && right_high;
   assign any_high   = left_high || right_high;
   assign touching   = (item.left_load < cfg.limit_left) ||
                       (item.right_load < cfg.limit_right);

   // next state
   always_comb begin
      phase_in         = phase_ff;
      hold_timer_in    = hold_timer_ff;
      timer_running_in = timer_running_ff;
      takeoff_left_in  = takeoff_left_ff;
      takeoff_right_in = takeoff_right_ff;
      pending_left_in  = pending_left_ff;
      pending_right_in = pending_right_ff;
      landing_left_in  = landing_left_ff;
      landing_right_in = landing_right_ff;
      unique case (item.kind)
         REQ_SAMPLE: begin
            if (phase_in == PH_GROUND) begin
               phase_in = PH_ROLL;
            end
            if (lifted && phase_in == PH_ROLL) begin
               phase_in         = PH_LIFT_PEND;
               hold_timer_in    = '0;
               timer_running_in = 1'b1;
            end
            if (touching && phase_in == PH_LIFT_PEND) begin
               timer_running_in = 1'b0;
               phase_in         = PH_ROLL;
               takeoff_left_in  = sat_add(takeoff_left_in, pending_left_in);
               takeoff_right_in = sat_add(takeoff_right_in, pending_right_in);
               pending_left_in  = '0;
               pending_right_in = '0;
            end
            if (touching && phase_in == PH_AIRBORNE) begin
               phase_in         = PH_TOUCH_PEND;
               hold_timer_in    = '0;
               timer_running_in = 1'b1;
            end
            if (any_high && phase_in == PH_TOUCH_PEND) begin
               timer_running_in = 1'b0;
               phase_in         = PH_AIRBORNE;
               pending_left_in  = '0;
               pending_right_in = '0;
            end
            if (touching && phase_in == PH_LANDED) begin
               phase_in         = PH_DONE;
               landing_left_in  = sat_add(landing_left_in, pending_left_in);
               landing_right_in = sat_add(landing_right_in, pending_right_in);
            end
         end
         REQ_TICK: begin
            if (timer_running_ff) begin
               hold_timer_in = hold_timer_ff + {{(CNT_W-1){1'b0}}, 1'b1};
               if (hold_timer_in >= cfg.hold_ticks) begin
                  timer_running_in = 1'b0;
                  if (phase_ff == PH_LIFT_PEND) begin
                     phase_in         = PH_AIRBORNE;
                     pending_left_in  = '0;
                     pending_right_in = '0;
                  end else if (phase_ff == PH_TOUCH_PEND) begin
                     phase_in         = PH_LANDED;
                     pending_left_in  = '0;
                     pending_right_in = '0;
                  end
               end
            end
         end
         REQ_PULSE_LEFT, REQ_PULSE_RIGHT: begin
            case (phase_ff)
               PH_ROLL: begin
                  if (item.kind == REQ_PULSE_RIGHT) begin
                     takeoff_right_in = sat_add(takeoff_right_ff, 16'd1);
                  end else begin
                     takeoff_left_in = sat_add(takeoff_left_ff, 16'd1);
                  end
               end
               PH_LIFT_PEND, PH_TOUCH_PEND: begin
                  if (item.kind == REQ_PULSE_RIGHT) begin
                     pending_right_in = sat_add(pending_right_ff, 16'd1);
                  end else begin
                     pending_left_in = sat_add(pending_left_ff, 16'd1);
                  end
               end
               PH_LANDED, PH_DONE: begin
                  if (item.kind == REQ_PULSE_RIGHT) begin
                     landing_right_in = sat_add(landing_right_ff, 16'd1);
                  end else begin
                     landing_left_in = sat_add(landing_left_ff, 16'd1);
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // result of this beat
   always_comb begin
      result.phase          = phase_in;
      result.takeoff_pulses = larger(takeoff_left_in, takeoff_right_in);
      result.landing_pulses = larger(landing_left_in, landing_right_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_GROUND;
         hold_timer_ff    <= '0;
         timer_running_ff <= 1'b0;
         takeoff_left_ff  <= '0;
         takeoff_right_ff <= '0;
         pending_left_ff  <= '0;
         pending_right_ff <= '0;
         landing_left_ff  <= '0;
         landing_right_ff <= '0;
      end else if (step_en) begin
         phase_ff         <= phase_in;
         hold_timer_ff    <= hold_timer_in;
         timer_running_ff <= timer_running_in;
         takeoff_left_ff  <= takeoff_left_in;
         takeoff_right_ff <= takeoff_right_in;
         pending_left_ff  <= pending_left_in;
         pending_right_ff <= pending_right_in;
         landing_left_ff  <= landing_left_in;
         landing_right_ff <= landing_right_in;
      end
   end

   `GRPC_ASSERT_SAME(a_timer_in_pending, clock, reset, timer_running_ff, (phase_ff == PH_LIFT_PEND) || (phase_ff == PH_TOUCH_PEND), "hold timer runs outside a pending phase")
   `GRPC_ASSERT_SAME(a_pending_clear, clock, reset, (phase_ff == PH_GROUND) || (phase_ff == PH_ROLL) || (phase_ff == PH_AIRBORNE), (pending_left_ff == '0) && (pending_right_ff == '0), "pending counts held outside pending phases")
   `GRPC_ASSERT_SAME(a_counts_monotonic, clock, reset, !$past(reset), (takeoff_left_ff >= $past(takeoff_left_ff)) && (landing_right_ff >= $past(landing_right_ff)), "roll counter decreased")
   `GRPC_ASSERT_NEXT(a_idle_tick, clock, reset, step_en && (item.kind == REQ_TICK) && !timer_running_ff, phase_ff == $past(phase_ff), "tick with stopped timer moved the phase")

endmodule

[hdl/ground_roll_phase_counter_unit.sv]
// ----------------------------------------------------------------------------
// Ground roll phase counter unit
// Flight phase tracking and takeoff / landing roll wheel pulse counting.
//
//   Channel  Dir  Handshake              Payload
//   req      in   req_tvalid/req_tready  tdata: left_load, right_load; tuser: req_type
//   rsp      out  rsp_tvalid/rsp_tready  tdata: phase, takeoff_pulses, landing_pulses
//   csr      in   csr_we (no wait)       csr_index, csr_wdata
//
// One beat per cycle sustained while rsp_tready is high; a result passes the input and result registers.
// The input register feeds the phase engine, whose update lands in the
// state and the result register in the same cycle.
// Reset is synchronous: state, valids and config return to reset values; data registers are not reset.
// A stalled rsp holds its result; the input register still takes one beat.
// ----------------------------------------------------------------------------
module ground_roll_phase_counter_unit
   import grpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // left_load[9:0], right_load[19:10], zero pad
   input  logic [1:0]            req_tuser,   // req_type[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,   // phase[2:0], takeoff_pulses[18:3],
                                              // landing_pulses[34:19], zero pad
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic          in_valid_ff, in_valid_in;
   step_item_type in_item_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_data_ff;
   result_type    step_result;
   cfg_type       cfg;
   logic          advance;
   logic          req_beat;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_item_ff.kind       <= req_kind_type'(req_tuser);
         in_item_ff.left_load  <= req_tdata[9:0];
         in_item_ff.right_load <= req_tdata[19:10];
      end
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   grpc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   grpc_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff.landing_pulses, rsp_data_ff.takeoff_pulses,
                        rsp_data_ff.phase};

endmodule
